### design/b64e_pkg.sv
// ----------------------------------------------------------------------------
// b64e_pkg
// Shared types, constants and the symbol lookup for the Base64-style encoder.
// ----------------------------------------------------------------------------
package b64e_pkg;

  // complete groups per output line
  localparam int LINE_GROUPS = 19;
  localparam int GRP_W       = 6;

  localparam logic [7:0] PAD_CHAR = 8'h7E;
  localparam logic [7:0] NL_CHAR  = 8'h0A;
  localparam logic [7:0] CH_UPPER = 8'h41;  // 'A'
  localparam logic [7:0] CH_LOWER = 8'h61;  // 'a'
  localparam logic [7:0] CH_DIGIT = 8'h30;  // '0'
  localparam logic [7:0] CH_SYM62 = 8'h2A;  // '*'
  localparam logic [7:0] CH_SYM63 = 8'h2D;  // '-'

  localparam logic [2:0] IDX_PAD2 = 3'd2;
  localparam logic [2:0] IDX_LAST = 3'd3;
  localparam logic [2:0] IDX_NL   = 3'd4;

  typedef enum logic [1:0] {
    JOB_FULL  = 2'd0,  // three bytes, four symbols, optional newline
    JOB_PART1 = 2'd1,  // one byte, two symbols, two pads
    JOB_PART2 = 2'd2   // two bytes, three symbols, one pad
  } job_kind_t;

  typedef struct packed {
    job_kind_t  kind;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic       nl;
    logic       last;
  } job_t;

  typedef struct packed {
    logic [1:0]       held_count;
    logic [GRP_W-1:0] groups;
  } front_sts_t;

  typedef struct packed {
    logic [1:0] count;
  } fifo_sts_t;

  function automatic logic [7:0] sym(input logic [5:0] v);
    logic [7:0] c;
    if (v < 6'd26) begin
      c = CH_UPPER + {2'b00, v};
    end else if (v < 6'd52) begin
      c = CH_LOWER + {2'b00, v} - 8'd26;
    end else if (v < 6'd62) begin
      c = CH_DIGIT + {2'b00, v} - 8'd52;
    end else if (v == 6'd62) begin
      c = CH_SYM62;
    end else begin
      c = CH_SYM63;
    end
    return c;
  endfunction

endpackage

### design/b64e_if.sv
// ----------------------------------------------------------------------------
// b64e_if
// Valid/ready channel interfaces for the encoder's byte input and char output.
// ----------------------------------------------------------------------------
interface b64e_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       final_byte;

  modport source(output valid, output data_byte, output final_byte, input ready);
  modport sink(input valid, input data_byte, input final_byte, output ready);
endinterface

interface b64e_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       out_last;

  modport source(output valid, output out_char, output out_last, input ready);
  modport sink(input valid, input out_char, input out_last, output ready);
endinterface

### design/base64_stream_encoder.sv
// ----------------------------------------------------------------------------
// base64_stream_encoder
// Byte-serial Base64-style encoder with optional line breaks.
// ----------------------------------------------------------------------------
// in_ch carries one byte per transaction plus final_byte on the message's
// last byte. out_ch carries one character per transaction; out_last marks
// the final character of a message. cfg_wr_en/cfg_wr_data set the newline
// enable; write it only while the encoder is idle.
// The front gathers bytes into groups of three and queues one job per group
// (or per partial group at the end of a message) in a two-entry queue. The
// back sends each job's four or five characters, one per cycle while out_ch
// is ready. A job passes through the queue and then the back's job register
// before its first character is valid.
// The one-character-per-cycle output sequencer limits the byte throughput.
// Bytes that only fill the holding register are taken at one per cycle
// while the queue is not full.
// Reset clears the held bytes, the line counter, the newline enable and the
// queue. When the receiver stalls, the current character holds; the queue
// fills after two more jobs and in_ch.ready then drops.
// ----------------------------------------------------------------------------
module base64_stream_encoder
  import b64e_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  b64e_in_if.sink    in_ch,
  b64e_out_if.source out_ch,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data
);

  logic       q_push;
  logic       q_full;
  logic       q_pop;
  logic       q_valid;
  job_t       push_job;
  job_t       pop_job;
  front_sts_t front_sts;
  fifo_sts_t  fifo_sts;

  b64e_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_job       (push_job),
    .sts         (front_sts)
  );

  b64e_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .pop_job  (pop_job),
    .sts      (fifo_sts)
  );

  b64e_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_job   (pop_job),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

`ifndef ASSERT_OFF
  // a job must never be issued into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("job pushed into full queue");

  // the line counter stays below one line's worth of groups
  a_groups_range: assert property (@(posedge clk) disable iff (!rst_n)
    front_sts.groups < GRP_W'(LINE_GROUPS))
    else $error("line group counter out of range");

  // a final byte always leaves the holding register and counter empty
  a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && in_ch.final_byte) |=>
      (front_sts.held_count == 2'd0 && front_sts.groups == '0))
    else $error("state not cleared after final byte");

  // the queue never holds more than its two entries
  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_sts.count != 2'd3)
    else $error("queue level out of range");
`endif

endmodule

### design/b64e_front.sv
// ----------------------------------------------------------------------------
// b64e_front
// Accepts bytes, gathers groups of three, counts line groups and issues
// one encode job per group or per partial group at end of message.
// ----------------------------------------------------------------------------
module b64e_front
  import b64e_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  b64e_in_if.sink     in_ch,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  input  logic        q_full,
  output logic        q_push,
  output job_t        q_job,
  output front_sts_t  sts
);

  logic [7:0]       held0_r, held0_nxt;
  logic [7:0]       held1_r, held1_nxt;
  logic [1:0]       count_r, count_nxt;
  logic [GRP_W-1:0] groups_r, groups_nxt;
  logic             nl_en_r;
  logic             fire;
  logic [GRP_W-1:0] groups_inc;
  logic             wrap;

  assign in_ch.ready = !q_full;
  assign fire        = in_ch.valid && in_ch.ready;
  assign groups_inc  = groups_r + GRP_W'(1);
  assign wrap        = (groups_inc >= GRP_W'(LINE_GROUPS));

  always_comb begin
    held0_nxt  = held0_r;
    held1_nxt  = held1_r;
    count_nxt  = count_r;
    groups_nxt = groups_r;
    q_push     = 1'b0;
    q_job      = '{kind: JOB_FULL, b0: held0_r, b1: held1_r, b2: in_ch.data_byte,
                   nl: wrap && nl_en_r, last: in_ch.final_byte};
    if (fire) begin
      if (count_r == 2'd2) begin
        q_push     = 1'b1;
        count_nxt  = 2'd0;
        groups_nxt = (wrap || in_ch.final_byte) ? '0 : groups_inc;
      end else if (in_ch.final_byte) begin
        q_push     = 1'b1;
        count_nxt  = 2'd0;
        groups_nxt = '0;
        q_job.last = 1'b1;
        q_job.nl   = 1'b0;
        q_job.b2   = 8'h00;
        if (count_r == 2'd1) begin
          q_job.kind = JOB_PART2;
          q_job.b1   = in_ch.data_byte;
        end else begin
          q_job.kind = JOB_PART1;
          q_job.b0   = in_ch.data_byte;
          q_job.b1   = 8'h00;
        end
      end else if (count_r == 2'd1) begin
        held1_nxt = in_ch.data_byte;
        count_nxt = 2'd2;
      end else begin
        held0_nxt = in_ch.data_byte;
        count_nxt = 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= 2'd0;
      groups_r <= '0;
      nl_en_r  <= 1'b0;
    end else begin
      count_r  <= count_nxt;
      groups_r <= groups_nxt;
      if (cfg_wr_en) begin
        nl_en_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held0_r <= 8'h00;
      held1_r <= 8'h00;
    end else begin
      held0_r <= held0_nxt;
      held1_r <= held1_nxt;
    end
  end

  assign sts = '{held_count: count_r, groups: groups_r};

endmodule

### design/b64e_fifo.sv
// ----------------------------------------------------------------------------
// b64e_fifo
// Two-entry job queue between the front and the character sequencer.
// ----------------------------------------------------------------------------
module b64e_fifo
  import b64e_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  job_t      push_job,
  output logic      full,
  input  logic      pop,
  output logic      valid,
  output job_t      pop_job,
  output fifo_sts_t sts
);

  job_t       mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r, count_nxt;
  logic       do_push;
  logic       do_pop;

  assign full    = (count_r == 2'd2);
  assign valid   = (count_r != 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && valid;
  assign pop_job = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      count_r <= count_nxt;
      if (do_push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  assign sts = '{count: count_r};

endmodule

### design/b64e_back.sv
// ----------------------------------------------------------------------------
// b64e_back
// Character sequencer: holds one job and sends its characters one per
// transaction, loading the next job as the last character leaves.
// ----------------------------------------------------------------------------
module b64e_back
  import b64e_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  job_t        q_job,
  output logic        q_pop,
  b64e_out_if.source  out_ch
);

  job_t       job_r;
  logic       busy_r;
  logic [2:0] idx_r, idx_nxt;
  logic [2:0] last_idx;
  logic       at_last;
  logic       fire;
  logic       load;
  logic [5:0] s0, s1, s2, s3;

  assign last_idx = job_r.nl ? IDX_NL : IDX_LAST;
  assign at_last  = (idx_r == last_idx);
  assign fire     = out_ch.valid && out_ch.ready;
  assign load     = q_valid && (!busy_r || (fire && at_last));
  assign q_pop    = load;

  assign s0 = job_r.b0[7:2];
  assign s1 = {job_r.b0[1:0], job_r.b1[7:4]};
  assign s2 = {job_r.b1[3:0], job_r.b2[7:6]};
  assign s3 = job_r.b2[5:0];

  always_comb begin
    unique case (idx_r)
      3'd0:     out_ch.out_char = sym(s0);
      3'd1:     out_ch.out_char = sym(s1);
      IDX_PAD2: out_ch.out_char = (job_r.kind == JOB_PART1) ? PAD_CHAR : sym(s2);
      IDX_LAST: out_ch.out_char = (job_r.kind == JOB_FULL) ? sym(s3) : PAD_CHAR;
      default:  out_ch.out_char = NL_CHAR;
    endcase
  end

  assign out_ch.valid    = busy_r;
  assign out_ch.out_last = job_r.last && at_last;

  always_comb begin
    idx_nxt = idx_r;
    if (load) begin
      idx_nxt = 3'd0;
    end else if (fire) begin
      idx_nxt = idx_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= 3'd0;
    end else begin
      idx_r <= idx_nxt;
      if (load) begin
        busy_r <= 1'b1;
      end else if (fire && at_last) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      job_r <= q_job;
    end
  end

endmodule
